/* hdl/swhm_pkg.sv */
// ----------------------------------------------------------------------
// swhm_pkg
// shared sizes, request codes and transaction types of the window matcher
// ----------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package swhm_pkg;

	localparam int unsigned NUM_COLORS = 64;
	localparam int unsigned MAX_WINDOW = 64;

	// field widths fixed by the interface
	localparam int unsigned REQ_W = 2;
	localparam int unsigned COL_W = 7;
	localparam int unsigned TC_W  = 7;
	localparam int unsigned POS_W = 16;

	// derived widths
	localparam int unsigned CIDX_W = $clog2(NUM_COLORS);
	localparam int unsigned HP_W   = $clog2(MAX_WINDOW);
	localparam int unsigned WL_W   = $clog2(MAX_WINDOW + 1);
	localparam int unsigned MIS_W  = $clog2(NUM_COLORS + 1);
	localparam int unsigned LEN_W  = ((WL_W > TC_W) ? WL_W : TC_W) + 1;
	localparam int unsigned ENT_W  = 2 * WL_W;

	// result queue
	localparam int unsigned OQ_DEPTH = 4;
	localparam int unsigned OQ_AW    = $clog2(OQ_DEPTH);

	// request codes
	localparam logic [REQ_W-1:0] REQ_LOAD    = 2'd0;
	localparam logic [REQ_W-1:0] REQ_PUSH    = 2'd1;
	localparam logic [REQ_W-1:0] REQ_RESTART = 2'd2;

	// colour table operations
	localparam logic [1:0] TALLY_EVICT   = 2'd0;
	localparam logic [1:0] TALLY_ADD     = 2'd1;
	localparam logic [1:0] TALLY_LOAD    = 2'd2;
	localparam logic [1:0] TALLY_RESTART = 2'd3;

	typedef struct packed {
		logic [REQ_W-1:0] req_type;
		logic [COL_W-1:0] color;
		logic [TC_W-1:0]  target_count;
	} req_t;

	typedef struct packed {
		logic             match;
		logic [POS_W-1:0] start_position;
		logic             error;
	} res_t;

	typedef struct packed {
		logic              en;
		logic [1:0]        op;
		logic [CIDX_W-1:0] addr;
		logic [TC_W-1:0]   tc;
	} tally_req_t;

	typedef struct packed {
		logic             load_err;
		logic [MIS_W-1:0] mis_next;
		logic [WL_W-1:0]  wl;
	} tally_rsp_t;

	typedef struct packed {
		logic [REQ_W-1:0]  req_type;
		logic              ok;
		logic [CIDX_W-1:0] ci;
		logic [TC_W-1:0]   tc;
		logic              do_evict;
		logic              do_add;
		logic              full;
		logic [POS_W-1:0]  start;
	} item_t;

endpackage

`default_nettype wire

/* hdl/swhm_ram.sv */
// ----------------------------------------------------------------------
// swhm_ram
// simple dual-port ram, one write and one registered read, read-first
// ----------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module swhm_ram #(
	parameter  int unsigned W  = 8,
	parameter  int unsigned D  = 64,
	localparam int unsigned AW = $clog2(D)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);

	logic [W-1:0] mem_q [D];
	logic [W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

/* hdl/swhm_tally.sv */
// ----------------------------------------------------------------------
// swhm_tally
// colour table: target and window count per colour, read-modify-write
// with forwarding, mismatch counter, window length and target bookkeeping
// ----------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module swhm_tally (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [swhm_pkg::CIDX_W-1:0]         rd_addr,
	input  swhm_pkg::tally_req_t                op,
	output swhm_pkg::tally_rsp_t                rsp
);
	import swhm_pkg::*;

	logic [ENT_W-1:0]      rd_data;
	logic [ENT_W-1:0]      wr_data;
	logic                  wr_en;
	logic                  clr;
	logic                  fwd;
	logic [WL_W-1:0]       cur_tgt;
	logic [WL_W-1:0]       cur_cnt;
	logic [WL_W-1:0]       cnt_new;
	logic                  was_off;
	logic                  now_off;
	logic [MIS_W-1:0]      mis_adj;
	logic [MIS_W-1:0]      mis_nx;
	logic [MIS_W-1:0]      nz_new;
	logic [LEN_W-1:0]      new_len;
	logic                  len_err;
	logic                  load_ok;

	logic [MIS_W-1:0]      mis_q;
	logic [MIS_W-1:0]      nz_q;
	logic [WL_W-1:0]       wl_q;
	logic [NUM_COLORS-1:0] tgt_vld_q;
	logic [NUM_COLORS-1:0] cnt_vld_q;
	logic                  wr_en_q;
	logic [CIDX_W-1:0]     wr_addr_q;
	logic [ENT_W-1:0]      wr_data_q;

	swhm_ram #(
		.W (ENT_W),
		.D (NUM_COLORS)
	) u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (op.addr),
		.wdata (wr_data),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	// write of the last edge is not yet visible in the read data
	assign fwd = wr_en_q && (wr_addr_q == op.addr);

	always_comb begin
		if (fwd) begin
			cur_tgt = wr_data_q[ENT_W-1:WL_W];
			cur_cnt = wr_data_q[WL_W-1:0];
		end else begin
			cur_tgt = tgt_vld_q[op.addr] ? rd_data[ENT_W-1:WL_W] : '0;
			cur_cnt = cnt_vld_q[op.addr] ? rd_data[WL_W-1:0] : '0;
		end
	end

	assign new_len = LEN_W'(wl_q) - LEN_W'(cur_tgt) + LEN_W'(op.tc);
	assign len_err = new_len > LEN_W'(MAX_WINDOW);
	assign nz_new  = nz_q - MIS_W'(cur_tgt != '0) + MIS_W'(op.tc != '0);

	always_comb begin
		cnt_new = cur_cnt;
		if (op.op == TALLY_ADD) begin
			cnt_new = cur_cnt + WL_W'(1);
		end else if (cur_cnt != '0) begin
			cnt_new = cur_cnt - WL_W'(1);
		end
	end

	assign was_off = cur_cnt != cur_tgt;
	assign now_off = cnt_new != cur_tgt;

	always_comb begin
		if (was_off && !now_off && (mis_q != '0)) begin
			mis_adj = mis_q - MIS_W'(1);
		end else if (!was_off && now_off) begin
			mis_adj = mis_q + MIS_W'(1);
		end else begin
			mis_adj = mis_q;
		end
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_data = {cur_tgt, cnt_new};
		clr     = 1'b0;
		mis_nx  = mis_q;
		load_ok = 1'b0;
		if (op.en) begin
			case (op.op)
				TALLY_EVICT, TALLY_ADD: begin
					wr_en  = 1'b1;
					mis_nx = mis_adj;
				end
				TALLY_LOAD: begin
					if (!len_err) begin
						load_ok = 1'b1;
						wr_en   = 1'b1;
						wr_data = {WL_W'(op.tc), {WL_W{1'b0}}};
						clr     = 1'b1;
						mis_nx  = nz_new;
					end
				end
				TALLY_RESTART: begin
					clr    = 1'b1;
					mis_nx = nz_q;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mis_q     <= '0;
			nz_q      <= '0;
			wl_q      <= '0;
			tgt_vld_q <= '0;
			cnt_vld_q <= '0;
			wr_en_q   <= 1'b0;
		end else begin
			mis_q   <= mis_nx;
			wr_en_q <= wr_en;
			if (wr_en) begin
				tgt_vld_q[op.addr] <= 1'b1;
			end
			// a restart empties every window count, and so does an accepted load
			if (clr) begin
				cnt_vld_q <= '0;
			end else if (wr_en) begin
				cnt_vld_q[op.addr] <= 1'b1;
			end
			if (load_ok) begin
				wl_q <= WL_W'(new_len);
				nz_q <= nz_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		wr_addr_q <= op.addr;
		wr_data_q <= wr_data;
	end

	assign rsp.load_err = op.en && (op.op == TALLY_LOAD) && len_err;
	assign rsp.mis_next = mis_nx;
	assign rsp.wl       = wl_q;

	a_reject_keeps_len: assert property (@(posedge clk) disable iff (!arst_n)
		(op.en && (op.op == TALLY_LOAD) && len_err) |=> $stable(wl_q))
		else $error("rejected load changed window length");

	a_restart_mismatch: assert property (@(posedge clk) disable iff (!arst_n)
		(op.en && (op.op == TALLY_RESTART)) |=> (mis_q == nz_q))
		else $error("restart left mismatch count off the nonzero target count");

endmodule

`default_nettype wire

/* hdl/swhm_outq.sv */
// ----------------------------------------------------------------------
// swhm_outq
// small result queue between the pipeline and the result channel
// ----------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module swhm_outq (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       wr_en,
	input  swhm_pkg::res_t             wr_data,
	output logic                       rd_valid,
	input  logic                       rd_stall,
	output swhm_pkg::res_t             rd_data,
	output logic [swhm_pkg::OQ_AW:0]   level
);
	import swhm_pkg::*;

	res_t             ent_q [OQ_DEPTH];
	logic [OQ_AW-1:0] wp_q;
	logic [OQ_AW-1:0] rp_q;
	logic [OQ_AW:0]   cnt_q;
	logic             pop;

	assign rd_valid = cnt_q != '0;
	assign rd_data  = ent_q[rp_q];
	assign level    = cnt_q;
	assign pop      = rd_valid && !rd_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr_en) begin
				wp_q <= (wp_q == OQ_AW'(OQ_DEPTH - 1)) ? '0 : wp_q + OQ_AW'(1);
			end
			if (pop) begin
				rp_q <= (rp_q == OQ_AW'(OQ_DEPTH - 1)) ? '0 : rp_q + OQ_AW'(1);
			end
			if (wr_en && !pop) begin
				cnt_q <= cnt_q + (OQ_AW + 1)'(1);
			end else if (!wr_en && pop) begin
				cnt_q <= cnt_q - (OQ_AW + 1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			ent_q[wp_q] <= wr_data;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr_en && !pop && (cnt_q == (OQ_AW + 1)'(OQ_DEPTH))))
		else $error("result queue overflow");

endmodule

`default_nettype wire

/* hdl/sliding_window_histogram_match.sv */
// ----------------------------------------------------------------------
// sliding_window_histogram_match
// reports every window of a colour stream whose colour counts equal the
// loaded target counts, with the 1-based start position of the window
// ----------------------------------------------------------------------
//
// channel  dir  handshake              transaction
// req      in   req_valid / req_stall  req_t: req_type, color, target_count
// res      out  res_valid / res_stall  res_t: match, start_position, error
//
// the colour table has one read port, used in turn by the evicted colour in
// s1 and the new colour in s2, so no new request enters while s1 is busy
// a result passes s1, s2 and s3 before it is written to the queue
// a load or restart holds off the next request while it is in s1 or s2
// reset is asynchronous; all tables are empty at once, no clearing pass
// a stalled result channel fills a four-entry queue, then stalls req
//
`timescale 1ns / 1ps
`default_nettype none

module sliding_window_histogram_match (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  swhm_pkg::req_t req,
	output logic           res_valid,
	input  logic           res_stall,
	output swhm_pkg::res_t res
);
	import swhm_pkg::*;

	// front end state
	logic [HP_W-1:0]   hp_q;
	logic [POS_W-1:0]  items_q;
	logic [WL_W-1:0]   fill_q;

	// pipeline
	logic              s1_v_s1;
	logic              s2_v_s2;
	logic              s3_v_s3;
	item_t             item_s1;
	item_t             item_s2;
	item_t             item_s3;
	logic [CIDX_W-1:0] old_s2;
	logic              err_s3;

	logic              accept;
	logic              col_ok;
	logic              push_go;
	logic              clr;
	logic [WL_W-1:0]   wl;
	logic [WL_W-1:0]   fill_nx;
	logic [HP_W-1:0]   hp_next;
	logic [WL_W:0]     slot_sum;
	logic [HP_W-1:0]   slot;
	logic [CIDX_W-1:0] hist_rdata;
	logic [CIDX_W-1:0] tally_raddr;
	item_t             in_item;
	tally_req_t        treq;
	tally_rsp_t        trsp;
	res_t              res_s3;
	logic [OQ_AW:0]    oq_level;
	logic [OQ_AW+1:0]  in_flight;

	assign wl = trsp.wl;

	// ---------------- request decode ----------------
	assign accept = req_valid && !req_stall;
	assign col_ok = (req.color != '0) && (32'(req.color) <= NUM_COLORS);

	// window is full once fill reaches the target length
	assign fill_nx = ((wl != '0) && (fill_q < wl)) ? fill_q + WL_W'(1) : fill_q;
	assign hp_next = (hp_q == HP_W'(MAX_WINDOW - 1)) ? '0 : hp_q + HP_W'(1);

	always_comb begin
		in_item.req_type = req.req_type;
		in_item.ci       = CIDX_W'(req.color - COL_W'(1));
		in_item.tc       = req.target_count;
		in_item.do_evict = (wl != '0) && (fill_q >= wl);
		in_item.do_add   = wl != '0;
		in_item.full     = (wl != '0) && (fill_nx >= wl);
		// start of the window that ends at this push
		in_item.start    = items_q + POS_W'(2) - POS_W'(wl);
		case (req.req_type)
			REQ_LOAD:    in_item.ok = col_ok;
			REQ_PUSH:    in_item.ok = col_ok;
			REQ_RESTART: in_item.ok = 1'b1;
			default:     in_item.ok = 1'b0;
		endcase
	end

	assign push_go = accept && (req.req_type == REQ_PUSH) && col_ok;

	// ---------------- colour history ring ----------------
	// slot leaving the window: (hp - wl) mod MAX_WINDOW
	assign slot_sum = (WL_W + 1)'(hp_q) + (WL_W + 1)'(MAX_WINDOW) - (WL_W + 1)'(wl);
	assign slot     = (slot_sum >= (WL_W + 1)'(MAX_WINDOW)) ?
		HP_W'(slot_sum - (WL_W + 1)'(MAX_WINDOW)) : HP_W'(slot_sum);

	// read-first: at full length the slot read equals the slot written
	swhm_ram #(
		.W (CIDX_W),
		.D (MAX_WINDOW)
	) u_hist (
		.clk   (clk),
		.we    (push_go),
		.waddr (hp_q),
		.wdata (in_item.ci),
		.raddr (slot),
		.rdata (hist_rdata)
	);

	// load accepted or restart: stream starts afresh
	assign clr = s2_v_s2 &&
		(((item_s2.req_type == REQ_LOAD) && item_s2.ok && !trsp.load_err) ||
		(item_s2.req_type == REQ_RESTART));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hp_q    <= '0;
			items_q <= '0;
			fill_q  <= '0;
		end else if (clr) begin
			hp_q    <= '0;
			items_q <= '0;
			fill_q  <= '0;
		end else if (push_go) begin
			hp_q    <= hp_next;
			items_q <= items_q + POS_W'(1);
			fill_q  <= fill_nx;
		end
	end

	// ---------------- pipeline ----------------
	// s1: evicted colour read from the colour table (target for a load)
	// s2: evict or load written back, new colour read
	// s3: new colour written back, result formed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_s1 <= 1'b0;
			s2_v_s2 <= 1'b0;
			s3_v_s3 <= 1'b0;
		end else begin
			s1_v_s1 <= accept;
			s2_v_s2 <= s1_v_s1;
			s3_v_s3 <= s2_v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= in_item;
		end
		item_s2 <= item_s1;
		old_s2  <= hist_rdata;
		item_s3 <= item_s2;
		err_s3  <= s2_v_s2 && (item_s2.req_type == REQ_LOAD) && item_s2.ok &&
			trsp.load_err;
	end

	// s1 and s2 are never busy together, so one read port serves both
	always_comb begin
		if (s1_v_s1) begin
			tally_raddr = ((item_s1.req_type == REQ_PUSH) && item_s1.do_evict) ?
				hist_rdata : item_s1.ci;
		end else begin
			tally_raddr = item_s2.ci;
		end
	end

	// s2 and s3 are never busy together, so one write port serves both
	always_comb begin
		treq = '0;
		treq.tc = item_s2.tc;
		if (s2_v_s2) begin
			case (item_s2.req_type)
				REQ_PUSH: begin
					treq.en   = item_s2.ok && item_s2.do_evict;
					treq.op   = TALLY_EVICT;
					treq.addr = old_s2;
				end
				REQ_LOAD: begin
					treq.en   = item_s2.ok;
					treq.op   = TALLY_LOAD;
					treq.addr = item_s2.ci;
				end
				REQ_RESTART: begin
					treq.en = 1'b1;
					treq.op = TALLY_RESTART;
				end
				default: begin
				end
			endcase
		end else if (s3_v_s3 && (item_s3.req_type == REQ_PUSH) && item_s3.ok &&
			item_s3.do_add) begin
			treq.en   = 1'b1;
			treq.op   = TALLY_ADD;
			treq.addr = item_s3.ci;
		end
	end

	swhm_tally u_tally (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_addr (tally_raddr),
		.op      (treq),
		.rsp     (trsp)
	);

	// ---------------- result ----------------
	always_comb begin
		res_s3.match = s3_v_s3 && (item_s3.req_type == REQ_PUSH) && item_s3.ok &&
			item_s3.do_add && item_s3.full && (trsp.mis_next == '0);
		res_s3.start_position = res_s3.match ? item_s3.start : '0;
		res_s3.error          = err_s3;
	end

	swhm_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (s3_v_s3),
		.wr_data  (res_s3),
		.rd_valid (res_valid),
		.rd_stall (res_stall),
		.rd_data  (res),
		.level    (oq_level)
	);

	// room in the queue for every transaction still in flight plus one more
	assign in_flight = (OQ_AW + 2)'(oq_level) + (OQ_AW + 2)'(s2_v_s2) +
		(OQ_AW + 2)'(s3_v_s3);

	assign req_stall = s1_v_s1 ||
		(s2_v_s2 && (item_s2.req_type != REQ_PUSH)) ||
		(in_flight >= (OQ_AW + 2)'(OQ_DEPTH));

	// ---------------- checks ----------------
	a_read_port_shared: assert property (@(posedge clk) disable iff (!arst_n)
		!(s1_v_s1 && s2_v_s2))
		else $error("two colour table reads in one cycle");

	a_write_port_shared: assert property (@(posedge clk) disable iff (!arst_n)
		!(s2_v_s2 && s3_v_s3))
		else $error("two colour table writes in one cycle");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= wl)
		else $error("window fill above window length");

endmodule

`default_nettype wire

/* tb/sv/sliding_window_histogram_match_test.sv */
// ----------------------------------------------------------------------
// sliding_window_histogram_match_test
// drives load, push and restart transactions into the window matcher with
// random idle and stall, predicts every result from a private copy of the
// colour tallies and checks each result field by field, in order
// ----------------------------------------------------------------------
`timescale 1ns / 1ps

module sliding_window_histogram_match_test;
	import swhm_pkg::*;

	// request code the block must ignore
	localparam logic [REQ_W-1:0] REQ_UNKNOWN = 2'd3;

	localparam int unsigned CYCLE_LIMIT   = 1_000_000;
	localparam int unsigned RANDOM_ITEMS  = 700;
	// results reach the queue from s3 after their request, leave some margin
	localparam int unsigned SETTLE_CYCLES = 20;

	// ------------------------------------------------------------------
	// predicted colour tallies and the results still awaited
	// ------------------------------------------------------------------
	class match_tracker;
		int unsigned target_tally[NUM_COLORS];
		int unsigned window_tally[NUM_COLORS];
		int unsigned recent_colors[MAX_WINDOW];
		int unsigned ring_head;
		logic [POS_W-1:0] position;
		int unsigned span;
		int unsigned off_colors;
		int unsigned filled;
		res_t awaited_results[$];
		int unsigned failures;

		function new();
			foreach (target_tally[i])
				target_tally[i] = 0;
			span = 0;
			failures = 0;
			restart_window();
		endfunction

		// empty window; every colour with a nonzero target starts out of step
		function void restart_window();
			foreach (window_tally[i])
				window_tally[i] = 0;
			foreach (recent_colors[i])
				recent_colors[i] = 0;
			ring_head = 0;
			position = '0;
			filled = 0;
			off_colors = 0;
			foreach (target_tally[i])
				if (target_tally[i] != 0)
					off_colors++;
		endfunction

		// move one colour tally up or down and keep the out-of-step count
		function void tally_step(int unsigned ci, bit up);
			bit was_off;
			bit now_off;
			was_off = window_tally[ci] != target_tally[ci];
			if (up)
				window_tally[ci]++;
			else if (window_tally[ci] != 0)
				window_tally[ci]--;
			now_off = window_tally[ci] != target_tally[ci];
			if (was_off && !now_off && off_colors != 0)
				off_colors--;
			else if (!was_off && now_off)
				off_colors++;
		endfunction

		function void note_request(req_t r);
			res_t want;
			int unsigned ci;
			int unsigned new_span;
			int unsigned slot;
			bit in_range;
			want = '0;
			in_range = r.color >= 1 && r.color <= NUM_COLORS;
			case (r.req_type)
				REQ_LOAD: begin
					if (in_range) begin
						ci = r.color - 1;
						new_span = span - target_tally[ci] + r.target_count;
						if (new_span > MAX_WINDOW) begin
							want.error = 1'b1;
						end else begin
							target_tally[ci] = r.target_count;
							span = new_span;
							restart_window();
						end
					end
				end
				REQ_PUSH: begin
					if (in_range) begin
						ci = r.color - 1;
						if (span != 0) begin
							if (filled >= span) begin
								slot = (ring_head + MAX_WINDOW - span) % MAX_WINDOW;
								tally_step(recent_colors[slot], 1'b0);
							end else begin
								filled++;
							end
							tally_step(ci, 1'b1);
						end
						recent_colors[ring_head] = ci;
						ring_head = (ring_head + 1) % MAX_WINDOW;
						position = position + 16'd1;
						if (span != 0 && filled >= span && off_colors == 0) begin
							want.match = 1'b1;
							want.start_position = position - POS_W'(span) + 16'd1;
						end
					end
				end
				REQ_RESTART: begin
					restart_window();
				end
				default: begin
				end
			endcase
			awaited_results.push_back(want);
		endfunction

		function void check_result(res_t got);
			res_t want;
			if (awaited_results.size() == 0) begin
				$display("%0t: result with none awaited: match %0d start %0d error %0d",
					$time, got.match, got.start_position, got.error);
				failures++;
				return;
			end
			want = awaited_results.pop_front();
			if (got.match !== want.match || got.start_position !== want.start_position ||
					got.error !== want.error) begin
				$display("%0t: expected match/start/error %0d/%0d/%0d, got %0d/%0d/%0d",
					$time, want.match, want.start_position, want.error,
					got.match, got.start_position, got.error);
				failures++;
			end
		endfunction

		function int unsigned pending();
			return awaited_results.size();
		endfunction
	endclass

	// ------------------------------------------------------------------
	// block and its signals
	// ------------------------------------------------------------------
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	res_t res;

	// when set, neither side idles
	bit calm = 1'b0;
	int unsigned cycle_count = 0;
	match_tracker tracker;

	sliding_window_histogram_match dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// monitor: sample both channels at the edge, before any update lands
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (arst_n) begin
			if (req_valid && !req_stall)
				tracker.note_request(req);
			if (res_valid && !res_stall)
				tracker.check_result(res);
		end
	end

	initial begin : watchdog
		wait (cycle_count >= CYCLE_LIMIT);
		$display("FAILED: results differ");
		$finish;
	end

	function automatic int unsigned pick_gap();
		if (calm)
			return 0;
		return $urandom_range(0, 7);
	endfunction

	// ------------------------------------------------------------------
	// result side: stall a random number of cycles before each transaction
	// ------------------------------------------------------------------
	initial begin : result_sink
		int unsigned hold;
		wait (arst_n);
		forever begin
			hold = pick_gap();
			if (hold != 0) begin
				res_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			res_stall <= 1'b0;
			do @(posedge clk); while (!res_valid);
		end
	end

	// ------------------------------------------------------------------
	// request side
	// ------------------------------------------------------------------

	// one transaction, after a random idle gap; returns on the accepting edge
	task automatic send_request(input logic [REQ_W-1:0] kind, input logic [COL_W-1:0] colour,
			input logic [TC_W-1:0] count);
		int unsigned gap;
		gap = pick_gap();
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= '{req_type: kind, color: colour, target_count: count};
		do @(posedge clk); while (req_stall);
	endtask

	// hold off until every awaited result is in
	task automatic wait_drained();
		req_valid <= 1'b0;
		@(posedge clk);
		while (tracker.pending() != 0)
			@(posedge clk);
	endtask

	// zero every target so a new pattern starts from an empty histogram
	task automatic clear_targets();
		int c;
		wait_drained();
		for (c = 0; c < NUM_COLORS; c++)
			if (tracker.target_tally[c] != 0)
				send_request(REQ_LOAD, COL_W'(c + 1), '0);
	endtask

	// small target histogram, then a stream mostly drawn from its colours,
	// with the odd restart, reload or stray colour mixed in
	task automatic run_pattern_phase(inout int unsigned counted);
		logic [COL_W-1:0] palette[4];
		logic [COL_W-1:0] stray;
		int unsigned kinds;
		int unsigned pushes;
		int unsigned roll;
		int k;
		clear_targets();
		kinds = $urandom_range(1, 4);
		for (k = 0; k < 4; k++)
			palette[k] = COL_W'($urandom_range(1, NUM_COLORS));
		if ($urandom_range(0, 7) == 0) begin
			// window at full capacity, one colour only
			kinds = 1;
			send_request(REQ_LOAD, palette[0], TC_W'(MAX_WINDOW));
			pushes = $urandom_range(MAX_WINDOW + 2, MAX_WINDOW + 20);
		end else begin
			for (k = 0; k < kinds; k++)
				send_request(REQ_LOAD, palette[k], TC_W'($urandom_range(1, 3)));
			pushes = $urandom_range(10, 40);
		end
		counted += kinds;
		repeat (pushes) begin
			roll = $urandom_range(0, 99);
			if (roll < 4) begin
				send_request(REQ_RESTART, COL_W'($urandom_range(0, 127)),
					TC_W'($urandom_range(0, 127)));
				counted++;
			end else if (roll < 7) begin
				send_request(REQ_LOAD, palette[$urandom_range(0, kinds - 1)],
					TC_W'($urandom_range(0, 4)));
				counted++;
			end else if (roll < 12) begin
				stray = COL_W'($urandom_range(0, 127));
				send_request(REQ_PUSH, stray, TC_W'($urandom_range(0, 127)));
				if (stray >= 1 && stray <= NUM_COLORS)
					counted++;
			end else begin
				send_request(REQ_PUSH, palette[$urandom_range(0, kinds - 1)],
					TC_W'($urandom_range(0, 127)));
				counted++;
			end
		end
	endtask

	// raw random transactions over every bit of every field
	task automatic run_noise_phase(inout int unsigned counted);
		logic [REQ_W-1:0] kind;
		logic [COL_W-1:0] colour;
		repeat ($urandom_range(5, 15)) begin
			kind = REQ_W'($urandom_range(0, 3));
			colour = COL_W'($urandom_range(0, 127));
			send_request(kind, colour, TC_W'($urandom_range(0, 127)));
			if (kind == REQ_RESTART ||
					(kind != REQ_UNKNOWN && colour >= 1 && colour <= NUM_COLORS))
				counted++;
		end
	endtask

	// ------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------
	initial begin : stimulus
		int unsigned counted;
		tracker = new();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// empty target: pushes are recorded but never match
		send_request(REQ_PUSH, 7'd1, 7'd0);
		send_request(REQ_PUSH, 7'd64, 7'd0);
		// colours out of range and the unused request code are ignored
		send_request(REQ_PUSH, 7'd0, 7'd0);
		send_request(REQ_PUSH, 7'd65, 7'd0);
		send_request(REQ_PUSH, 7'd127, 7'd127);
		send_request(REQ_LOAD, 7'd0, 7'd5);
		send_request(REQ_LOAD, 7'd127, 7'd127);
		send_request(REQ_UNKNOWN, 7'd127, 7'd127);
		// full capacity, then loads that would overflow it
		send_request(REQ_LOAD, 7'd1, 7'd64);
		send_request(REQ_LOAD, 7'd2, 7'd1);
		send_request(REQ_LOAD, 7'd64, 7'd127);
		// window of three: two of colour 1, one of colour 64
		send_request(REQ_LOAD, 7'd1, 7'd2);
		send_request(REQ_LOAD, 7'd64, 7'd1);
		// partial window first, then a run of matches as it slides
		send_request(REQ_PUSH, 7'd1, 7'd0);
		send_request(REQ_PUSH, 7'd64, 7'd0);
		send_request(REQ_PUSH, 7'd1, 7'd0);
		send_request(REQ_PUSH, 7'd1, 7'd0);
		send_request(REQ_PUSH, 7'd64, 7'd0);
		send_request(REQ_PUSH, 7'd2, 7'd0);
		// restart empties the window again
		send_request(REQ_RESTART, 7'd0, 7'd0);
		send_request(REQ_PUSH, 7'd1, 7'd0);
		send_request(REQ_LOAD, 7'd1, 7'd0);
		send_request(REQ_LOAD, 7'd64, 7'd0);

		// sender holds until the directed results are all back
		wait_drained();

		counted = 0;
		while (counted < RANDOM_ITEMS) begin
			calm = $urandom_range(0, 4) == 0;
			if ($urandom_range(0, 3) == 0)
				run_noise_phase(counted);
			else
				run_pattern_phase(counted);
		end
		calm = 1'b0;

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (tracker.failures == 0 && tracker.pending() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

/* files.f */
hdl/swhm_pkg.sv
hdl/swhm_ram.sv
hdl/swhm_tally.sv
hdl/swhm_outq.sv
hdl/sliding_window_histogram_match.sv
tb/sv/sliding_window_histogram_match_test.sv
